// ----- hdl/rltma_pkg.sv -----
package rltma_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned RAW_W      = 18;
  localparam int unsigned OFS_W      = 11;
  localparam int unsigned INTV_W     = 16;
  localparam int unsigned CORR_W     = 14;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [INTV_W-1:0] INTV_RESET = 16'd1000;
  localparam logic [CORR_W-1:0] CORR_MAX   = 14'd9999;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORR_OFFSET     = 1'b0,
    REG_SAMPLE_INTERVAL = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic valid;
    logic take;
  } ring_beat_t;

endpackage

// ----- hdl/rate_limited_temp_moving_average.sv -----
// channel  direction  handshake               payload
// in       input      in_valid_i/in_ready_o   now_ms_i, raw_temp_i
// out      output     out_valid_o/out_ready_i corrected_avg_o, uncorrected_avg_o, sample_taken_o
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one item per cycle unless back-pressure stalls the input; an item passes the sum, sum2, product and output registers
// the ring memory is read at accept and written when a taken beat other than the first leaves the sum stage
// every stage holds its beat under back-pressure, empty stages still take new items
// reset needs no clearing pass: the first sample stands in for unwritten entries
// cfg writes are never stalled and land directly in the config registers
module rate_limited_temp_moving_average #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [rltma_pkg::TIME_W-1:0]         now_ms_i,
  input  logic signed [rltma_pkg::RAW_W-1:0]   raw_temp_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [rltma_pkg::CORR_W-1:0]         corrected_avg_o,
  output logic signed [rltma_pkg::RAW_W-1:0]   uncorrected_avg_o,
  output logic                                 sample_taken_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rltma_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rltma_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import rltma_pkg::*;

  localparam int unsigned SUM_W = RAW_W + $clog2(RING_DEPTH);

  logic signed [OFS_W-1:0] offset_q;
  logic [INTV_W-1:0]       interval_q;
  ring_beat_t              ring_beat;
  logic signed [SUM_W-1:0] ring_sum;
  logic                    mean_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      interval_q <= INTV_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CORR_OFFSET:     offset_q   <= cfg_data_i[OFS_W-1:0];
        REG_SAMPLE_INTERVAL: interval_q <= cfg_data_i[INTV_W-1:0];
        default:             offset_q   <= offset_q;
      endcase
    end
  end

  rltma_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .now_ms_i         (now_ms_i),
    .raw_temp_i       (raw_temp_i),
    .sample_interval_i(interval_q),
    .beat_o           (ring_beat),
    .sum_o            (ring_sum),
    .dn_ready_i       (mean_ready)
  );

  rltma_mean #(
    .RING_DEPTH(RING_DEPTH)
  ) u_mean (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .beat_i           (ring_beat),
    .sum_i            (ring_sum),
    .up_ready_o       (mean_ready),
    .offset_i         (offset_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .corrected_avg_o  (corrected_avg_o),
    .uncorrected_avg_o(uncorrected_avg_o),
    .sample_taken_o   (sample_taken_o)
  );

  // a stalled sum beat keeps its value while the ring stage waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_beat.valid && !mean_ready |=> ring_beat.valid && $stable(ring_sum))
    else $error("sum beat changed while stalled");

  // an empty sum stage must always take a new item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ring_beat.valid |-> in_ready_o)
    else $error("input blocked with empty sum stage");

endmodule

// ----- hdl/rltma_ring.sv -----
module rltma_ring #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              in_valid_i,
  output logic                                              in_ready_o,
  input  logic [rltma_pkg::TIME_W-1:0]                      now_ms_i,
  input  logic signed [rltma_pkg::RAW_W-1:0]                raw_temp_i,
  input  logic [rltma_pkg::INTV_W-1:0]                      sample_interval_i,
  output rltma_pkg::ring_beat_t                             beat_o,
  output logic signed [rltma_pkg::RAW_W+$clog2(RING_DEPTH)-1:0] sum_o,
  input  logic                                              dn_ready_i
);
  import rltma_pkg::*;

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned SUM_W = RAW_W + IDX_W;
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(RING_DEPTH);

  logic signed [RAW_W-1:0] ring_mem [RING_DEPTH];

  logic                    first_pending_q;
  logic [TIME_W-1:0]       last_take_q;
  logic [IDX_W-1:0]        pos_q;
  logic [CNT_W-1:0]        fill_cnt_q;
  logic signed [RAW_W-1:0] first_raw_q;
  logic signed [RAW_W-1:0] rd_data_q;
  logic signed [SUM_W-1:0] sum_q;

  logic                    s1_valid_q;
  logic                    s1_take_q;
  logic                    s1_first_q;
  logic                    s1_fill_q;
  logic signed [RAW_W-1:0] s1_raw_q;
  logic [IDX_W-1:0]        s1_addr_q;

  logic [TIME_W-1:0]       due;
  logic                    take;
  logic [IDX_W-1:0]        nxt_pos;
  logic                    accept;
  logic                    s1_fire;
  logic signed [RAW_W-1:0] old_val;
  logic signed [SUM_W-1:0] sum_first;
  logic signed [SUM_W-1:0] sum_upd;

  always_comb begin
    due     = last_take_q + TIME_W'(sample_interval_i);
    take    = first_pending_q || (due <= now_ms_i);
    nxt_pos = (pos_q == LAST_IDX) ? '0 : pos_q + IDX_W'(1);
    accept  = in_valid_i && in_ready_o;
    s1_fire = s1_valid_q && dn_ready_i;
  end

  assign in_ready_o = !s1_valid_q || dn_ready_i;

  // per-take state and fill tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pending_q <= 1'b1;
      last_take_q     <= '0;
      pos_q           <= '0;
      fill_cnt_q      <= '0;
    end else if (accept && take) begin
      first_pending_q <= 1'b0;
      last_take_q     <= now_ms_i;
      pos_q           <= nxt_pos;
      if (!first_pending_q && (fill_cnt_q != FILL_FULL)) begin
        fill_cnt_q <= fill_cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && take && first_pending_q) begin
      first_raw_q <= raw_temp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_take_q  <= take;
      s1_first_q <= first_pending_q;
      s1_fill_q  <= (fill_cnt_q != FILL_FULL);
      s1_raw_q   <= raw_temp_i;
      s1_addr_q  <= nxt_pos;
    end
  end

  // while the ring is still filling, the first sample stands in for this read data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_data_q <= ring_mem[nxt_pos];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_take_q && !s1_first_q) begin
      ring_mem[s1_addr_q] <= s1_raw_q;
    end
  end

  always_comb begin
    old_val   = s1_fill_q ? first_raw_q : rd_data_q;
    sum_first = SUM_W'(s1_raw_q) * SUM_W'(RING_DEPTH);
    sum_upd   = sum_q + SUM_W'(s1_raw_q) - SUM_W'(old_val);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (s1_fire && s1_take_q) begin
      sum_q <= s1_first_q ? sum_first : sum_upd;
    end
  end

  assign beat_o.valid = s1_valid_q;
  assign beat_o.take  = s1_take_q;
  assign sum_o        = s1_take_q ? (s1_first_q ? sum_first : sum_upd) : sum_q;

endmodule

// ----- hdl/rltma_mean.sv -----
module rltma_mean #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  rltma_pkg::ring_beat_t                             beat_i,
  input  logic signed [rltma_pkg::RAW_W+$clog2(RING_DEPTH)-1:0] sum_i,
  output logic                                              up_ready_o,
  input  logic signed [rltma_pkg::OFS_W-1:0]                offset_i,
  output logic                                              out_valid_o,
  input  logic                                              out_ready_i,
  output logic [rltma_pkg::CORR_W-1:0]                      corrected_avg_o,
  output logic signed [rltma_pkg::RAW_W-1:0]                uncorrected_avg_o,
  output logic                                              sample_taken_o
);
  import rltma_pkg::*;

  localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
  localparam int unsigned SUM_W  = RAW_W + IDX_W;
  localparam int unsigned SH     = SUM_W + IDX_W;
  localparam int unsigned PROD_W = SUM_W + SH;
  localparam logic [SH-1:0] RECIP =
    SH'(((64'd1 << SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));
  localparam logic signed [RAW_W:0] CORR_HI = (RAW_W+1)'(CORR_MAX);

  logic                    v2_q;
  logic                    take2_q;
  logic signed [SUM_W-1:0] sum2_q;

  logic                    v3_q;
  logic                    take3_q;
  logic                    neg3_q;
  logic [PROD_W-1:0]       prod3_q;

  logic                    out_valid_q;
  logic [CORR_W-1:0]       corr_q;
  logic signed [RAW_W-1:0] mean_q;
  logic                    taken_q;

  logic                    ready2;
  logic                    ready3;
  logic                    ready_out;
  logic                    neg2;
  logic [SUM_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic [SUM_W-1:0]        quo;
  logic [SUM_W-1:0]        mean_full;
  logic signed [RAW_W-1:0] mean;
  logic signed [RAW_W:0]   corr_sum;
  logic [CORR_W-1:0]       corr_sat;

  assign ready_out  = !out_valid_q || out_ready_i;
  assign ready3     = !v3_q || ready_out;
  assign ready2     = !v2_q || ready3;
  assign up_ready_o = ready2;

  // floor division: negative sums are biased by depth minus one, then truncated
  always_comb begin
    neg2 = sum2_q[SUM_W-1];
    mag  = neg2 ? (~sum2_q + SUM_W'(RING_DEPTH)) : sum2_q;
    prod = PROD_W'(mag) * PROD_W'(RECIP);
  end

  always_comb begin
    quo       = prod3_q[PROD_W-1:SH];
    mean_full = neg3_q ? (~quo + SUM_W'(1)) : quo;
    mean      = mean_full[RAW_W-1:0];
    corr_sum  = (RAW_W+1)'(mean) + (RAW_W+1)'(offset_i);
    priority if (corr_sum < 0) begin
      corr_sat = '0;
    end else if (corr_sum > CORR_HI) begin
      corr_sat = CORR_MAX;
    end else begin
      corr_sat = corr_sum[CORR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready2) begin
        v2_q <= beat_i.valid;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
      if (ready_out) begin
        out_valid_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && beat_i.valid) begin
      take2_q <= beat_i.take;
      sum2_q  <= sum_i;
    end
    if (ready3 && v2_q) begin
      take3_q <= take2_q;
      neg3_q  <= neg2;
      prod3_q <= prod;
    end
    if (ready_out && v3_q) begin
      corr_q  <= corr_sat;
      mean_q  <= mean;
      taken_q <= take3_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign corrected_avg_o   = corr_q;
  assign uncorrected_avg_o = mean_q;
  assign sample_taken_o    = taken_q;

endmodule
